// ===== hw/rtl/stkc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the stack calculator machine.
// Depends on nothing; every other file of the block uses it.
package stkc_pkg;

  localparam int DATA_W  = 32;
  localparam int DEPTH_W = 5;
  localparam int ADDR_W  = 3;

  // Opcodes.
  localparam logic [7:0] OP_LIT  = 8'd0;
  localparam logic [7:0] OP_ADD  = 8'd1;
  localparam logic [7:0] OP_SUB  = 8'd2;
  localparam logic [7:0] OP_MUL  = 8'd3;
  localparam logic [7:0] OP_DIV  = 8'd4;
  localparam logic [7:0] OP_USER = 8'd5;

  // Result status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_UNDERFLOW = 3'd1;
  localparam logic [2:0] ST_OVERFLOW  = 3'd2;
  localparam logic [2:0] ST_INVALID   = 3'd3;
  localparam logic [2:0] ST_DIVZERO   = 3'd4;
  localparam logic [2:0] ST_SKIPPED   = 3'd5;

  // How the datapath wants the decoded instruction to be sequenced.
  localparam logic [1:0] ROUTE_DIRECT = 2'd0;
  localparam logic [1:0] ROUTE_ALU    = 2'd1;
  localparam logic [1:0] ROUTE_DIV    = 2'd2;

  // Register index, taken from paddr[2].
  localparam logic [0:0] REG_USER_VALUE = 1'b0;

  typedef struct packed {
    logic accept;
    logic alu_load;
    logic div_start;
    logic commit;
  } stkc_cmd_t;

  typedef struct packed {
    logic [1:0] route;
    logic       div_done;
    logic       out_free;
  } stkc_status_t;

endpackage

// ===== hw/rtl/stkc_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for instructions and results.
// Depends on stkc_pkg for the data and depth widths.
interface stkc_instr_if;
  logic              valid;
  logic              ready;
  logic [7:0]        mode;
  logic signed [7:0] literal_byte;
  logic              last_instruction;

  modport source (output valid, mode, literal_byte, last_instruction, input ready);
  modport sink   (input valid, mode, literal_byte, last_instruction, output ready);
endinterface

interface stkc_result_if;
  logic                                 valid;
  logic                                 ready;
  logic [2:0]                           status_code;
  logic signed [stkc_pkg::DATA_W-1:0]   top_value;
  logic                                 top_valid;
  logic [stkc_pkg::DEPTH_W-1:0]         stack_depth;
  logic                                 program_done;

  modport source (output valid, status_code, top_value, top_valid, stack_depth,
                  program_done, input ready);
  modport sink   (input valid, status_code, top_value, top_valid, stack_depth,
                  program_done, output ready);
endinterface

// ===== hw/rtl/stkc_div.sv =====
`timescale 1ns / 1ps
// Iterative signed 32-bit divider, truncating, one quotient bit per cycle.
// Depends on stkc_pkg.
module stkc_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [stkc_pkg::DATA_W-1:0]   dividend,
  input  logic [stkc_pkg::DATA_W-1:0]   divisor,
  output logic                          done,
  output logic [stkc_pkg::DATA_W-1:0]   quotient
);
  import stkc_pkg::*;

  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] dvsr;
  logic              neg;
  logic              busy;
  logic [4:0]        step;
  logic [DATA_W-1:0] a_mag;
  logic [DATA_W-1:0] b_mag;
  logic [DATA_W:0]   shifted;
  logic [DATA_W+1:0] diff;

  assign a_mag   = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
  assign b_mag   = divisor[DATA_W-1]  ? (~divisor + 1'b1)  : divisor;
  assign shifted = {rem, quo[DATA_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 5'd1;
        if (step == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Restoring division on magnitudes; the remainder always stays below the divisor.
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= a_mag;
      dvsr <= b_mag;
      neg  <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
    end else if (busy) begin
      if (!diff[DATA_W+1]) begin
        rem <= diff[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = neg ? (~quo + 1'b1) : quo;

endmodule

// ===== hw/rtl/stkc_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer of the stack calculator: takes an instruction, steps it through
// decode, arithmetic and commit. Depends on stkc_pkg.
module stkc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  stkc_pkg::stkc_status_t status,
  output stkc_pkg::stkc_cmd_t    cmd
);
  import stkc_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECODE = 2'd1;
  localparam logic [1:0] S_DIV    = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.accept    = in_valid && in_ready;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        unique case (status.route)
          ROUTE_ALU: begin
            cmd.alu_load = 1'b1;
            state_next   = S_COMMIT;
          end
          ROUTE_DIV: begin
            cmd.div_start = 1'b1;
            state_next    = S_DIV;
          end
          default: state_next = S_COMMIT;
        endcase
      end
      S_DIV: begin
        if (status.div_done) state_next = S_COMMIT;
      end
      S_COMMIT: begin
        // Hold the finished item until the result register is free.
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hw/rtl/stkc_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the stack calculator: stack memory, top-of-stack register,
// decode, ALU, divider and result register. Depends on stkc_pkg, stkc_if and stkc_div.
module stkc_dp #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  stkc_pkg::stkc_cmd_t           cmd,
  output stkc_pkg::stkc_status_t        status,
  input  logic [7:0]                    mode,
  input  logic [7:0]                    literal_byte,
  input  logic                          last_instruction,
  input  logic [stkc_pkg::DATA_W-1:0]   user_value,
  stkc_result_if.source                 result
);
  import stkc_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  logic [7:0]        mode_q;
  logic [7:0]        lit_q;
  logic              last_q;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [DATA_W-1:0] tos;
  logic [DATA_W-1:0] tos_next;
  logic              faulted;
  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [DATA_W-1:0] below;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic              wr_en;
  logic              is_push;
  logic              is_bin;
  logic              ok;
  logic [2:0]        err;
  logic [DATA_W-1:0] alu_res;
  logic [DATA_W-1:0] alu_val;
  logic [DATA_W-1:0] push_val;
  logic [DATA_W-1:0] bin_res;
  logic [DATA_W-1:0] div_q;
  logic              div_done;
  logic              out_valid;

  // The entry under the top is read continuously; it is registered and settles in the cycle after a commit.
  assign rd_addr = AW'(count - CW'(2));

  always_ff @(posedge clk) begin
    below <= mem[rd_addr];
    if (wr_en) mem[wr_addr] <= tos_next;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_q <= mode;
      lit_q  <= literal_byte;
      last_q <= last_instruction;
    end
  end

  assign is_push = (mode_q == OP_LIT) || (mode_q == OP_USER);
  assign is_bin  = (mode_q >= OP_ADD) && (mode_q <= OP_DIV);

  always_comb begin
    err = ST_OK;
    if (is_push) begin
      if (count >= CW'(STACK_DEPTH)) err = ST_OVERFLOW;
    end else if (!is_bin) begin
      err = ST_INVALID;
    end else if (count < CW'(2)) begin
      err = ST_UNDERFLOW;
    end else if ((mode_q == OP_DIV) && (tos == '0)) begin
      err = ST_DIVZERO;
    end
  end

  assign ok = !faulted && (err == ST_OK);

  always_comb begin
    if (!ok || is_push) begin
      status.route = ROUTE_DIRECT;
    end else if (mode_q == OP_DIV) begin
      status.route = ROUTE_DIV;
    end else begin
      status.route = ROUTE_ALU;
    end
  end
  assign status.div_done = div_done;
  assign status.out_free = !out_valid || result.ready;

  always_comb begin
    case (mode_q)
      OP_ADD:  alu_val = below + tos;
      OP_SUB:  alu_val = below - tos;
      default: alu_val = DATA_W'(below * tos);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.alu_load) alu_res <= alu_val;
  end

  stkc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (below),
    .divisor  (tos),
    .done     (div_done),
    .quotient (div_q)
  );

  assign push_val = (mode_q == OP_LIT) ? {{(DATA_W-8){lit_q[7]}}, lit_q} : user_value;
  assign bin_res  = (mode_q == OP_DIV) ? div_q : alu_res;

  always_comb begin
    count_next = count;
    tos_next   = tos;
    wr_en      = 1'b0;
    wr_addr    = rd_addr;
    if (ok && is_push) begin
      count_next = count + CW'(1);
      tos_next   = push_val;
      wr_en      = cmd.commit;
      wr_addr    = count[AW-1:0];
    end else if (ok && is_bin) begin
      count_next = count - CW'(1);
      tos_next   = bin_res;
      wr_en      = cmd.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      faulted   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        count     <= count_next;
        faulted   <= !last_q && (faulted || (err != ST_OK));
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      tos                 <= tos_next;
      result.status_code  <= faulted ? ST_SKIPPED : err;
      result.top_value    <= (count_next != '0) ? tos_next : '0;
      result.top_valid    <= (count_next != '0);
      result.stack_depth  <= DEPTH_W'(count_next);
      result.program_done <= last_q;
    end
  end

  assign result.valid = out_valid;

endmodule

// ===== hw/rtl/stack_calculator_machine_core.sv =====
`timescale 1ns / 1ps
// Top level of the stack calculator machine: configuration port, sequencer
// and datapath. Depends on stkc_pkg, stkc_if, stkc_ctrl, stkc_dp and stkc_div.
//
// Usage: instructions arrive on the instr channel (mode, literal_byte,
// last_instruction) and each one yields exactly one item on the result
// channel (status, top of stack, depth, end-of-program flag). A transfer
// takes place on a clock edge with valid and ready both high.
// An instruction is taken only when the previous one has committed. Push,
// add, subtract, multiply, faults and skipped items go from transfer through
// decode to commit and result; a divide also waits for the divider, which
// yields one quotient bit per cycle.
// The user value register sits at byte addresses 0 to 3 (paddr[2] low) of the
// APB-style port; pready is tied high and writes at addresses 4 to 7 are ignored.
// Synchronous reset empties the stack, clears the fault flag, drops any
// pending result and sets the user value to zero. The stack memory itself
// is not cleared; entries are only read after being pushed.
// If the receiver stalls, the result register holds its item; a further
// instruction may be taken and run up to commit, where it waits.
module stack_calculator_machine_core #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  stkc_instr_if.sink                    instr,
  stkc_result_if.source                 result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [stkc_pkg::ADDR_W-1:0]   paddr,
  input  logic [stkc_pkg::DATA_W-1:0]   pwdata,
  output logic [stkc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import stkc_pkg::*;

  logic [DATA_W-1:0] user_value;
  stkc_cmd_t         cmd;
  stkc_status_t      status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      user_value <= '0;
    end else if (psel && penable && pwrite && pready
                 && (paddr[2:2] == REG_USER_VALUE)) begin
      user_value <= pwdata;
    end
  end

  assign prdata = (paddr[2:2] == REG_USER_VALUE) ? user_value : '0;

  stkc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (instr.valid),
    .in_ready (instr.ready),
    .status   (status),
    .cmd      (cmd)
  );

  stkc_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .mode             (instr.mode),
    .literal_byte     (instr.literal_byte),
    .last_instruction (instr.last_instruction),
    .user_value       (user_value),
    .result           (result)
  );

endmodule
